/* sv/psw_pkg.sv */
`timescale 1ns / 1ps
package psw_pkg;

  localparam int MAX_STEPS_DEF    = 8;
  localparam int COEF_BITS_DEF    = 16;
  localparam int CORDIC_ITERS_DEF = 16;

  localparam logic [3:0] STEP_RESET = 4'd4;
  localparam logic [3:0] STEP_MIN   = 4'd3;
  localparam logic       REG_STEP_COUNT = 1'b0;

  localparam logic signed [31:0] Q_ONE  = 32'sd1073741824;
  localparam logic signed [31:0] Q_HALF = 32'sd536870912;
  localparam logic signed [31:0] Q_S60  = 32'sd929887697;
  localparam logic signed [31:0] Q_C72  = 32'sd331804471;
  localparam logic signed [31:0] Q_S72  = 32'sd1021189159;
  localparam logic signed [31:0] Q_C36  = 32'sd868675383;
  localparam logic signed [31:0] Q_S36  = 32'sd631129609;
  localparam logic signed [31:0] Q_C7A  = 32'sd669467077;
  localparam logic signed [31:0] Q_S7A  = 32'sd839485162;
  localparam logic signed [31:0] Q_C7B  = 32'sd238930034;
  localparam logic signed [31:0] Q_S7B  = 32'sd1046820875;
  localparam logic signed [31:0] Q_C7C  = 32'sd967407956;
  localparam logic signed [31:0] Q_S7C  = 32'sd465879117;
  localparam logic signed [31:0] Q_R45  = 32'sd759250125;

  localparam logic signed [31:0] ROM_COS [6][8] = '{
    '{Q_ONE, -Q_HALF, -Q_HALF, 0, 0, 0, 0, 0},
    '{Q_ONE, 0, -Q_ONE, 0, 0, 0, 0, 0},
    '{Q_ONE, Q_C72, -Q_C36, -Q_C36, Q_C72, 0, 0, 0},
    '{Q_ONE, Q_HALF, -Q_HALF, -Q_ONE, -Q_HALF, Q_HALF, 0, 0},
    '{Q_ONE, Q_C7A, -Q_C7B, -Q_C7C, -Q_C7C, -Q_C7B, Q_C7A, 0},
    '{Q_ONE, Q_R45, 0, -Q_R45, -Q_ONE, -Q_R45, 0, Q_R45}
  };

  localparam logic signed [31:0] ROM_SIN [6][8] = '{
    '{0, Q_S60, -Q_S60, 0, 0, 0, 0, 0},
    '{0, Q_ONE, 0, -Q_ONE, 0, 0, 0, 0},
    '{0, Q_S72, Q_S36, -Q_S36, -Q_S72, 0, 0, 0},
    '{0, Q_S60, Q_S60, 0, -Q_S60, -Q_S60, 0, 0},
    '{0, Q_S7A, Q_S7B, Q_S7C, -Q_S7C, -Q_S7B, -Q_S7A, 0},
    '{0, Q_R45, Q_ONE, Q_R45, 0, -Q_R45, -Q_ONE, -Q_R45}
  };

  localparam logic [31:0] ATAN_ROM [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // round Q2.30 to cb fraction bits, ties away from zero
  function automatic logic signed [31:0] coef_round(input logic signed [31:0] q,
                                                    input int cb);
    logic [31:0] m;
    logic [31:0] r;
    m = q[31] ? 32'(-q) : 32'(q);
    r = (m + (32'd1 << (29 - cb))) >> (30 - cb);
    return q[31] ? -$signed(r) : $signed(r);
  endfunction

endpackage

/* sv/phase_shift_wrapped_phase_top.sv */
`timescale 1ns / 1ps
// N-step phase-shift wrapped phase. One pixel word (eight sample bytes) is taken
// per clock while in_stall is low; a phase word leaves after passing through the
// lane multiply stage, the merge adder, the quadrant fold, one register per
// CORDIC iteration and the output round/saturate register. The whole pipe
// advances together, so out_stall holds everything; in_stall is high only while
// a result waits on a stalled output. step_count (byte address 0) selects N,
// clamped to 3..MAX_STEPS; write it only while the pipe is empty.
module phase_shift_wrapped_phase_top #(
  parameter int MAX_STEPS    = psw_pkg::MAX_STEPS_DEF,
  parameter int COEF_BITS    = psw_pkg::COEF_BITS_DEF,
  parameter int CORDIC_ITERS = psw_pkg::CORDIC_ITERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_sample_0,
  input  logic [7:0]         in_sample_1,
  input  logic [7:0]         in_sample_2,
  input  logic [7:0]         in_sample_3,
  input  logic [7:0]         in_sample_4,
  input  logic [7:0]         in_sample_5,
  input  logic [7:0]         in_sample_6,
  input  logic [7:0]         in_sample_7,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_wrapped_phase,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import psw_pkg::*;

  localparam int PW = COEF_BITS + 11;
  localparam int SW = PW + 3;
  localparam int W  = COEF_BITS + 15;
  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] Z_PI  = ZW'(64'sd2147483648);
  localparam logic [3:0]           N_MAX = 4'(MAX_STEPS);

  // config
  logic [3:0] step_count_r;
  logic [2:0] rom_sel;
  logic [3:0] n_clamp;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {28'd0, step_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= STEP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_STEP_COUNT) begin
      step_count_r <= cfg_pwdata[3:0];
    end
  end

  always_comb begin
    n_clamp = step_count_r;
    if (n_clamp < STEP_MIN) n_clamp = STEP_MIN;
    if (n_clamp > N_MAX) n_clamp = N_MAX;
  end
  assign rom_sel = 3'(n_clamp - STEP_MIN);

  // pipeline control
  localparam int NV = CORDIC_ITERS + 4;
  logic          adv;
  logic [NV-1:0] vld_r;

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], in_valid};
    end
  end

  // lanes
  logic [7:0]          samples [8];
  logic signed [PW-1:0] prod_c [MAX_STEPS];
  logic signed [PW-1:0] prod_s [MAX_STEPS];

  assign samples = '{in_sample_0, in_sample_1, in_sample_2, in_sample_3,
                     in_sample_4, in_sample_5, in_sample_6, in_sample_7};

  for (genvar t = 0; t < MAX_STEPS; t++) begin : g_lane
    psw_lane #(.T(t), .CB(COEF_BITS), .PW(PW)) u_lane (
      .clk(clk), .adv(adv), .sample(samples[t]), .rom_sel(rom_sel),
      .prod_c_r(prod_c[t]), .prod_s_r(prod_s[t])
    );
  end

  logic signed [SW-1:0] sum_c;
  logic signed [SW-1:0] sum_s;

  psw_merge #(.LANES(MAX_STEPS), .PW(PW), .SW(SW)) u_merge (
    .clk(clk), .adv(adv), .prod_c(prod_c), .prod_s(prod_s),
    .sum_c_r(sum_c), .sum_s_r(sum_s)
  );

  // fold left half plane into right half, start angle +/- pi
  logic signed [W-1:0]  xs [CORDIC_ITERS+1];
  logic signed [W-1:0]  ys [CORDIC_ITERS+1];
  logic signed [ZW-1:0] zs [CORDIC_ITERS+1];
  logic                 zero_r [CORDIC_ITERS+1];
  logic signed [W-1:0]  sx;
  logic signed [W-1:0]  sy;

  assign sx = W'(sum_c);
  assign sy = W'(sum_s);

  logic signed [W-1:0]  x0_r;
  logic signed [W-1:0]  y0_r;
  logic signed [ZW-1:0] z0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_r[0] <= (sum_c == '0) && (sum_s == '0);
      if (sx[W-1]) begin
        x0_r <= -sx;
        y0_r <= -sy;
        z0_r <= sy[W-1] ? -Z_PI : Z_PI;
      end else begin
        x0_r <= sx;
        y0_r <= sy;
        z0_r <= '0;
      end
    end
  end

  assign xs[0] = x0_r;
  assign ys[0] = y0_r;
  assign zs[0] = z0_r;

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    psw_cordic_stage #(.I(i), .W(W), .ZW(ZW)) u_stage (
      .clk(clk), .adv(adv), .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
      .x_r(xs[i+1]), .y_r(ys[i+1]), .z_r(zs[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) zero_r[i+1] <= zero_r[i];
    end
  end

  // round to pi/32768 and saturate
  logic signed [ZW-1:0]  z_rnd;
  logic signed [ZW-17:0] ph;
  logic signed [15:0]    phase_nxt;
  logic signed [15:0]    phase_r;

  assign z_rnd = zs[CORDIC_ITERS] + ZW'(32768);
  assign ph    = (ZW-16)'(z_rnd >>> 16);

  always_comb begin
    if (zero_r[CORDIC_ITERS]) phase_nxt = '0;
    else if (ph > (ZW-16)'(32767)) phase_nxt = 16'sh7fff;
    else if (ph < -(ZW-16)'(32768)) phase_nxt = -16'sh8000;
    else phase_nxt = 16'(ph);
  end

  always_ff @(posedge clk) begin
    if (adv) phase_r <= phase_nxt;
  end

  assign out_wrapped_phase = phase_r;
endmodule

/* sv/psw_lane.sv */
`timescale 1ns / 1ps
module psw_lane #(
  parameter int T  = 0,
  parameter int CB = psw_pkg::COEF_BITS_DEF,
  parameter int PW = CB + 11
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [7:0]           sample,
  input  logic [2:0]           rom_sel,
  output logic signed [PW-1:0] prod_c_r,
  output logic signed [PW-1:0] prod_s_r
);
  import psw_pkg::*;

  logic signed [CB+1:0] coef_c;
  logic signed [CB+1:0] coef_s;
  logic signed [8:0]    samp_s;

  assign coef_c = (CB+2)'(coef_round(ROM_COS[rom_sel][T], CB));
  assign coef_s = (CB+2)'(coef_round(ROM_SIN[rom_sel][T], CB));
  assign samp_s = $signed({1'b0, sample});

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_c_r <= PW'(samp_s * coef_c);
      prod_s_r <= PW'(samp_s * coef_s);
    end
  end
endmodule

/* sv/psw_merge.sv */
`timescale 1ns / 1ps
module psw_merge #(
  parameter int LANES = psw_pkg::MAX_STEPS_DEF,
  parameter int PW    = psw_pkg::COEF_BITS_DEF + 11,
  parameter int SW    = PW + 3
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic signed [PW-1:0] prod_c [LANES],
  input  logic signed [PW-1:0] prod_s [LANES],
  output logic signed [SW-1:0] sum_c_r,
  output logic signed [SW-1:0] sum_s_r
);
  logic signed [SW-1:0] sum_c_nxt;
  logic signed [SW-1:0] sum_s_nxt;

  always_comb begin
    sum_c_nxt = '0;
    sum_s_nxt = '0;
    for (int t = 0; t < LANES; t++) begin
      sum_c_nxt = sum_c_nxt + SW'(prod_c[t]);
      sum_s_nxt = sum_s_nxt + SW'(prod_s[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_c_r <= sum_c_nxt;
      sum_s_r <= sum_s_nxt;
    end
  end
endmodule

/* sv/psw_cordic_stage.sv */
`timescale 1ns / 1ps
module psw_cordic_stage #(
  parameter int I  = 0,
  parameter int W  = psw_pkg::COEF_BITS_DEF + 15,
  parameter int ZW = 34
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic signed [W-1:0]  x_in,
  input  logic signed [W-1:0]  y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [W-1:0]  x_r,
  output logic signed [W-1:0]  y_r,
  output logic signed [ZW-1:0] z_r
);
  import psw_pkg::*;

  logic signed [ZW-1:0] ang;
  logic signed [W-1:0]  dx;
  logic signed [W-1:0]  dy;

  assign ang = $signed({{(ZW-32){1'b0}}, ATAN_ROM[I]});
  assign dx  = y_in >>> I;
  assign dy  = x_in >>> I;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!y_in[W-1]) begin
        x_r <= x_in + dx;
        y_r <= y_in - dy;
        z_r <= z_in + ang;
      end else begin
        x_r <= x_in - dx;
        y_r <= y_in + dy;
        z_r <= z_in - ang;
      end
    end
  end
endmodule

/* sv/psw_checker.sv */
`timescale 1ns / 1ps
module psw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_wrapped_phase
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_wrapped_phase))
    else $error("result word changed while stalled");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");
endmodule

bind phase_shift_wrapped_phase_top psw_checker u_psw_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_wrapped_phase(out_wrapped_phase)
);

/* bench/tb_phase_shift_wrapped_phase_top.sv */
`timescale 1ns / 1ps
module tb_phase_shift_wrapped_phase_top;
  import psw_pkg::*;

  localparam int LIMIT = 400000;

  // angle table in units of pi/2^31
  localparam longint ATAN_PI31 [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };

  // Q2.30 coefficient tables, rows indexed by N-3
  localparam int COS_Q30 [6][8] = '{
    '{1073741824, -536870912, -536870912, 0, 0, 0, 0, 0},
    '{1073741824, 0, -1073741824, 0, 0, 0, 0, 0},
    '{1073741824, 331804471, -868675383, -868675383, 331804471, 0, 0, 0},
    '{1073741824, 536870912, -536870912, -1073741824, -536870912, 536870912, 0, 0},
    '{1073741824, 669467077, -238930034, -967407956, -967407956, -238930034,
      669467077, 0},
    '{1073741824, 759250125, 0, -759250125, -1073741824, -759250125, 0, 759250125}
  };
  localparam int SIN_Q30 [6][8] = '{
    '{0, 929887697, -929887697, 0, 0, 0, 0, 0},
    '{0, 1073741824, 0, -1073741824, 0, 0, 0, 0},
    '{0, 1021189159, 631129609, -631129609, -1021189159, 0, 0, 0},
    '{0, 929887697, 929887697, 0, -929887697, -929887697, 0, 0},
    '{0, 839485162, 1046820875, 465879117, -465879117, -1046820875, -839485162, 0},
    '{0, 759250125, 1073741824, 759250125, 0, -759250125, -1073741824, -759250125}
  };

  typedef logic [7:0] pixel_t [8];

  class phase_scoreboard;
    logic signed [15:0] pending [$];
    int mismatches;
    int checked;

    function longint q30_to_q16(int q);
      longint m;
      longint r;
      m = (q < 0) ? -longint'(q) : longint'(q);
      r = (m + (64'sd1 << 13)) >>> 14;
      return (q < 0) ? -r : r;
    endfunction

    function logic signed [15:0] wrapped_phase(pixel_t s, logic [3:0] steps);
      int n;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      longint ph;
      n = steps < 3 ? 3 : (steps > 8 ? 8 : steps);
      x = 0;
      y = 0;
      z = 0;
      for (int t = 0; t < n; t++) begin
        x += longint'(s[t]) * q30_to_q16(COS_Q30[n-3][t]);
        y += longint'(s[t]) * q30_to_q16(SIN_Q30[n-3][t]);
      end
      if (x == 0 && y == 0) return 16'sd0;
      if (x < 0) begin
        z = (y >= 0) ? (64'sd1 << 31) : -(64'sd1 << 31);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += ATAN_PI31[i];
        end else begin
          x -= dx; y += dy; z -= ATAN_PI31[i];
        end
      end
      ph = (z + 32768) >>> 16;
      if (ph > 32767) ph = 32767;
      if (ph < -32768) ph = -32768;
      return ph[15:0];
    endfunction

    function void note_pixel(pixel_t s, logic [3:0] steps);
      pending.push_back(wrapped_phase(s, steps));
    endfunction

    function void check_phase(logic signed [15:0] got);
      logic signed [15:0] want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected phase word %0d", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("phase: expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic [7:0] in_s [8] = '{default: 8'd0};
  logic out_valid;
  logic out_stall = 0;
  logic in_stall;
  logic signed [15:0] out_wrapped_phase;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  phase_scoreboard sb = new();
  logic [3:0] cur_steps = STEP_RESET;
  int cycles = 0;
  int stall_mode = 0;
  int sent = 0;

  phase_shift_wrapped_phase_top u_top (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_sample_0(in_s[0]), .in_sample_1(in_s[1]), .in_sample_2(in_s[2]),
    .in_sample_3(in_s[3]), .in_sample_4(in_s[4]), .in_sample_5(in_s[5]),
    .in_sample_6(in_s[6]), .in_sample_7(in_s[7]),
    .out_valid, .out_stall, .out_wrapped_phase,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("phase_shift_wrapped_phase_top: mismatch");
      $finish;
    end
  end

  // result side: check, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_phase(out_wrapped_phase);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (cycles % 7) < 4;
    endcase
  end

  task automatic cfg_write(logic [3:0] v);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {REG_STEP_COUNT, 2'b00}; cfg_pwdata <= ($urandom & ~32'hF) | 32'(v);
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    cur_steps = v;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (CORDIC_ITERS_DEF + 8) @(posedge clk);
  endtask

  // one word, held until accepted
  task automatic send_pixel(pixel_t s);
    in_valid <= 1;
    for (int i = 0; i < 8; i++) in_s[i] <= s[i];
    do @(posedge clk); while (in_stall);
    sb.note_pixel(s, cur_steps);
    sent++;
  endtask

  task automatic idle(int n);
    in_valid <= 0;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 8; k++) in_s[k] <= 8'($urandom);
      @(posedge clk);
    end
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 8; i++) begin
      case (kind)
        0: p[i] = 8'd0;
        1: p[i] = 8'd255;
        2: p[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        3: p[i] = 8'(127 + $urandom_range(0, 2));
        default: p[i] = 8'($urandom);
      endcase
    end
    return p;
  endfunction

  task automatic random_phase(int count);
    int left;
    left = count;
    while (left > 0) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && left > 0; b++, left--) send_pixel(rand_pixel());
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 6));
    end
    idle(1);
  endtask

  initial begin
    pixel_t p;
    logic [3:0] plan [10] = '{4'd3, 4'd8, 4'd5, 4'd0, 4'd15, 4'd6, 4'd7, 4'd2, 4'd9, 4'd4};
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed at reset N: zero pixel, flat pixel, single peaks, extremes
    foreach (p[i]) p[i] = 0;
    send_pixel(p);
    foreach (p[i]) p[i] = 8'd255;
    send_pixel(p);
    for (int k = 0; k < 8; k++) begin
      foreach (p[i]) p[i] = (i == k) ? 8'd255 : 8'd0;
      send_pixel(p);
    end
    // negative x with y exactly zero (angle pi saturates), its complement, flat single-bit pixels
    foreach (p[i]) p[i] = 0;
    p[2] = 8'd255;
    send_pixel(p);
    foreach (p[i]) p[i] = (i == 2) ? 8'd0 : 8'd255;
    send_pixel(p);
    for (int b = 0; b < 8; b++) begin
      foreach (p[i]) p[i] = 8'd1 << b;
      send_pixel(p);
    end
    idle(1);
    drain();

    foreach (plan[k]) begin
      cfg_write(plan[k]);
      stall_mode = k % 4;
      random_phase(160);
      drain();
    end
    stall_mode = 0;
    drain();

    $display("sent %0d pixel words over %0d step settings (incl. out-of-range)", sent, 11);
    $display("checked %0d phase words, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("phase_shift_wrapped_phase_top: match");
    else
      $display("phase_shift_wrapped_phase_top: mismatch");
    $finish;
  end
endmodule

/* sim.f */
sv/psw_pkg.sv
sv/psw_lane.sv
sv/psw_merge.sv
sv/psw_cordic_stage.sv
sv/phase_shift_wrapped_phase_top.sv
sv/psw_checker.sv
bench/tb_phase_shift_wrapped_phase_top.sv
